### rtl/vumlt_pkg.sv
`default_nettype none
package vumlt_pkg;

	// Block length default and fixed field widths
	localparam int SAMPLES_PER_BLOCK_DEF = 8;
	localparam int SAMPLE_W = 12;
	localparam int ROWS_W = 5;
	localparam int CFG_IDX_W = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DC_MIDPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_ROWS = 2'd2;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] DC_MIDPOINT_RST = 12'd2048;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 12'd2000;
	localparam logic [ROWS_W-1:0] BAR_ROWS_RST = 5'd8;

	// Smoothing filter: (7*old + 3*new) / 10, numerator below 2^16
	localparam int SMOOTH_NUM_W = 16;
	localparam logic [SMOOTH_NUM_W-1:0] SMOOTH_OLD_WEIGHT = 16'd7;
	localparam logic [SMOOTH_NUM_W-1:0] SMOOTH_NEW_WEIGHT = 16'd3;
	localparam logic [SAMPLE_W-1:0] SMOOTH_DIVISOR = 12'd10;

	// Divide by ten as a multiply by the rounded-up reciprocal and a shift,
	// exact for every numerator below 2^SMOOTH_NUM_W
	localparam int SMOOTH_SHIFT = SMOOTH_NUM_W + $clog2(SMOOTH_DIVISOR);
	localparam int SMOOTH_RECIP_W = SMOOTH_NUM_W + 1;
	localparam logic [SMOOTH_RECIP_W-1:0] SMOOTH_RECIP = SMOOTH_RECIP_W'(
		((64'd1 << SMOOTH_SHIFT) + 64'(SMOOTH_DIVISOR) - 64'd1) / 64'(SMOOTH_DIVISOR));

	// Back end sequencer states
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_AVG,
		BK_FILT,
		BK_SCALE,
		BK_ROWS,
		BK_EMIT
	} back_state_t;

endpackage
`default_nettype wire

### rtl/vumlt_front.sv
`default_nettype none
module vumlt_front import vumlt_pkg::*; #(
	parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK),
	localparam int SUM_W = SAMPLE_W + CNT_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [SAMPLE_W-1:0] adc_sample,
	input  wire logic [SAMPLE_W-1:0] dc_midpoint,
	output logic                     push,
	output logic [SUM_W-1:0]         push_sum
);

	logic [SAMPLE_W-1:0] amp;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                last;

	// Remove the DC midpoint and rectify
	always_comb begin
		if (adc_sample >= dc_midpoint) begin
			amp = adc_sample - dc_midpoint;
		end else begin
			amp = dc_midpoint - adc_sample;
		end
	end

	// Close the block on its final sample
	assign last = (cnt_q == CNT_W'(SAMPLES_PER_BLOCK - 1));
	assign push = accept && last;
	assign push_sum = sum_q + SUM_W'(amp);

	// Accumulate the block sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= push_sum;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/vumlt_fifo.sv
`default_nettype none
module vumlt_fifo import vumlt_pkg::*; #(
	parameter int WIDTH = SAMPLE_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  full,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// Store incoming block sums
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/vumlt_div.sv
`default_nettype none
module vumlt_div import vumlt_pkg::*; #(
	parameter int DW = 17,
	localparam int CNT_W = $clog2(DW + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DW-1:0]       dividend,
	input  wire logic [SAMPLE_W-1:0] divisor,
	output logic                     done,
	output logic [DW-1:0]            quotient
);

	logic [SAMPLE_W-1:0] rem_q;
	logic [SAMPLE_W-1:0] dsr_q;
	logic [DW-1:0]       quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SAMPLE_W:0]   trial;
	logic                fits;

	// One restoring step: shift in the next dividend bit, try the subtract
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits = (trial >= {1'b0, dsr_q});

	assign done = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= SAMPLE_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[SAMPLE_W-1:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	// Count steps and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/vumlt_back.sv
`default_nettype none
module vumlt_back import vumlt_pkg::*; #(
	parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF,
	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK),
	localparam int SUM_W = SAMPLE_W + CNT_W,
	localparam int DIV_W = SAMPLE_W + ROWS_W
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire logic [SUM_W-1:0]    q_data,
	output logic                     q_pop,
	input  wire logic [SAMPLE_W-1:0] full_scale_level,
	input  wire logic [ROWS_W-1:0]   bar_rows,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SAMPLE_W-1:0]      smoothed_level,
	output logic [ROWS_W-1:0]        lit_rows
);

	// Block average as a multiply by the rounded-up reciprocal of the block
	// length and a shift, exact for every block sum
	localparam int AVG_SHIFT = SUM_W + CNT_W;
	localparam int AVG_RECIP_W = SUM_W + 1;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP = AVG_RECIP_W'(
		((64'd1 << AVG_SHIFT) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK));

	back_state_t                      state_q;
	back_state_t                      state_nxt;
	logic                             div_start;
	logic [DIV_W-1:0]                 div_dividend;
	logic [SAMPLE_W-1:0]              div_divisor;
	logic                             div_done;
	logic [DIV_W-1:0]                 div_quo;
	logic [SAMPLE_W-1:0]              avg_q;
	logic [SMOOTH_NUM_W-1:0]          num_q;
	logic [SAMPLE_W-1:0]              filtered_q;
	logic [ROWS_W-1:0]                rows_q;
	logic                             out_valid_q;
	logic [SAMPLE_W-1:0]              smoothed_level_q;
	logic [ROWS_W-1:0]                lit_rows_q;
	logic                             load_out;
	logic [SUM_W+AVG_RECIP_W-1:0]     avg_prod;
	logic [SMOOTH_NUM_W-1:0]          filt_num;
	logic [SMOOTH_NUM_W+SMOOTH_RECIP_W-1:0] smooth_prod;
	logic [DIV_W-1:0]                 rows_prod;
	logic [SAMPLE_W-1:0]              fs;

	// Block average from the sum at the head of the queue
	assign avg_prod = {{AVG_RECIP_W{1'b0}}, q_data} * {{SUM_W{1'b0}}, AVG_RECIP};
	// Smoothing numerator from the previous level and the block average
	assign filt_num = {4'd0, filtered_q} * SMOOTH_OLD_WEIGHT
		+ {4'd0, avg_q} * SMOOTH_NEW_WEIGHT;
	assign smooth_prod = {{SMOOTH_RECIP_W{1'b0}}, num_q}
		* {{SMOOTH_NUM_W{1'b0}}, SMOOTH_RECIP};
	// Bar numerator from the freshly smoothed level
	assign rows_prod = {5'd0, filtered_q} * {12'd0, bar_rows};
	assign fs = (full_scale_level == '0) ? SAMPLE_W'(1) : full_scale_level;

	assign div_dividend = rows_prod;
	assign div_divisor = fs;

	vumlt_div #(
		.DW(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Sequence average, smoothing and the bar divide
	always_comb begin
		state_nxt = state_q;
		q_pop = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					state_nxt = BK_AVG;
				end
			end
			BK_AVG: begin
				state_nxt = BK_FILT;
			end
			BK_FILT: begin
				state_nxt = BK_SCALE;
			end
			BK_SCALE: begin
				div_start = 1'b1;
				state_nxt = BK_ROWS;
			end
			BK_ROWS: begin
				if (div_done) begin
					state_nxt = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	// Capture the block average as its sum leaves the queue
	always_ff @(posedge clk) begin
		if (q_pop) begin
			avg_q <= avg_prod[AVG_SHIFT +: SAMPLE_W];
		end
	end

	// Hold the smoothing numerator
	always_ff @(posedge clk) begin
		if (state_q == BK_AVG) begin
			num_q <= filt_num;
		end
	end

	// Hold the smoothed level across blocks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= '0;
		end else if (state_q == BK_FILT) begin
			filtered_q <= smooth_prod[SMOOTH_SHIFT +: SAMPLE_W];
		end
	end

	// Saturate the row count at the configured bar length
	always_ff @(posedge clk) begin
		if (state_q == BK_ROWS && div_done) begin
			if (div_quo > DIV_W'(bar_rows)) begin
				rows_q <= bar_rows;
			end else begin
				rows_q <= div_quo[ROWS_W-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			smoothed_level_q <= filtered_q;
			lit_rows_q <= rows_q;
		end
	end

	assign out_valid = out_valid_q;
	assign smoothed_level = smoothed_level_q;
	assign lit_rows = lit_rows_q;

endmodule
`default_nettype wire

### rtl/vu_meter_level_tracker.sv
// VU meter level tracker.
// Input channel: one raw 12-bit converter code per item (adc_sample, in_valid,
// in_stall). The front end removes the DC midpoint, rectifies and adds to a
// block sum, taking one item per cycle while in_stall is low. Every
// SAMPLES_PER_BLOCK items the sum goes into a two-entry queue. The back end
// forms the block average and the (7*old + 3*avg)/10 smoothing by reciprocal
// multiplication, registering the average, the numerator and the smoothed
// level in turn, then divides level*rows by the full scale in a restoring
// divider, one quotient bit per cycle over the 17-bit bar numerator.
// The back end works on one block sum at a time while the front end goes on
// accumulating; in_stall rises when the queue is full.
// A held result sits in the output register while out_stall is high; the
// back end finishes the next block meanwhile and then waits for it to drain.
// Reset clears the block sum, sample count, smoothed level and queue and
// loads midpoint 2048, full scale 2000 and eight rows. Configuration writes
// (cfg_wr_en, cfg_index, cfg_data) take effect on the next clock edge.
`default_nettype none
module vu_meter_level_tracker import vumlt_pkg::*; #(
	parameter int SAMPLES_PER_BLOCK = SAMPLES_PER_BLOCK_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SAMPLE_W-1:0]  cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [SAMPLE_W-1:0]  adc_sample,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [SAMPLE_W-1:0]       smoothed_level,
	output logic [ROWS_W-1:0]         lit_rows
);

	localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK);
	localparam int SUM_W = SAMPLE_W + CNT_W;

	logic [SAMPLE_W-1:0] dc_midpoint_q;
	logic [SAMPLE_W-1:0] full_scale_q;
	logic [ROWS_W-1:0]   bar_rows_q;
	logic                in_accept;
	logic                q_push;
	logic [SUM_W-1:0]    q_push_data;
	logic                q_pop;
	logic [SUM_W-1:0]    q_pop_data;
	logic                q_full;
	logic                q_empty;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_midpoint_q <= DC_MIDPOINT_RST;
			full_scale_q <= FULL_SCALE_RST;
			bar_rows_q <= BAR_ROWS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DC_MIDPOINT: dc_midpoint_q <= cfg_data;
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				REG_BAR_ROWS: bar_rows_q <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall input while the queue has no room
	assign in_stall = q_full;
	assign in_accept = in_valid && !in_stall;

	vumlt_front #(
		.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.adc_sample  (adc_sample),
		.dc_midpoint (dc_midpoint_q),
		.push        (q_push),
		.push_sum    (q_push_data)
	);

	vumlt_fifo #(
		.WIDTH(SUM_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	vumlt_back #(
		.SAMPLES_PER_BLOCK(SAMPLES_PER_BLOCK)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_data           (q_pop_data),
		.q_pop            (q_pop),
		.full_scale_level (full_scale_q),
		.bar_rows         (bar_rows_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.smoothed_level   (smoothed_level),
		.lit_rows         (lit_rows)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("block sum pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("block sum popped from an empty queue");

	a_rows_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (lit_rows <= bar_rows_q))
		else $error("lit rows above configured bar length");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
	import vumlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCK_LEN = SAMPLES_PER_BLOCK_DEF;
	// Margin for the back end to go quiet after the last reading
	localparam int DRAIN_WAIT = 120;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_WAIT = 13;
	localparam int REPORT_MAX = 10;
	localparam int RANDOM_PHASES = 10;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] level;
		logic [ROWS_W-1:0]   rows;
	} reading_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                typed;
		logic [SAMPLE_W-1:0] level;
		logic [ROWS_W-1:0]   rows;
	} probe_row_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] fs;
		logic [ROWS_W-1:0]   rows;
	} setting_t;

	typedef enum int {
		STY_NOISE,
		STY_FAR,
		STY_QUIET,
		STY_SWING,
		STY_TONE
	} block_style_t;

	// Opening probes at reset settings: a silent block, a block pinned at the
	// bottom rail (level 614, two rows), then a mix of both rails and near-midpoint codes
	localparam probe_row_t PROBES [24] = '{
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b0, 12'd0, 5'd0},
		'{12'd2048, 1'b1, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b1, 12'd614, 5'd2},
		'{12'd4095, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd4095, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0},
		'{12'd2047, 1'b0, 12'd0, 5'd0},
		'{12'd2049, 1'b0, 12'd0, 5'd0},
		'{12'd4095, 1'b0, 12'd0, 5'd0},
		'{12'd0, 1'b0, 12'd0, 5'd0}
	};

	// Fixed corner settings: rails for midpoint, zero and tiny full scale,
	// zero rows and rows above sixteen
	localparam setting_t CORNERS [5] = '{
		'{12'd4095, 12'd1, 5'd16},
		'{12'd0, 12'd4095, 5'd1},
		'{12'd2048, 12'd0, 5'd0},
		'{12'd4095, 12'd0, 5'd31},
		'{12'd1000, 12'd500, 5'd17}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DC_MIDPOINT;
	logic [SAMPLE_W-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  adc_sample = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [SAMPLE_W-1:0]  smoothed_level;
	logic [ROWS_W-1:0]    lit_rows;

	// Predictor state and its copy of the registers
	int unsigned         run_sum;
	int unsigned         run_count;
	logic [SAMPLE_W-1:0] held_level;
	logic [SAMPLE_W-1:0] mid_reg;
	logic [SAMPLE_W-1:0] fs_reg;
	logic [ROWS_W-1:0]   rows_reg;

	reading_t due_readings[$];
	int       bad_count = 0;
	int       hold_left = 0;
	int       idle_cycles = 0;
	bit       tx_idle_en = 1'b1;
	bit       rx_idle_en = 1'b1;

	vu_meter_level_tracker #(
		.SAMPLES_PER_BLOCK(BLOCK_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.smoothed_level(smoothed_level),
		.lit_rows(lit_rows)
	);

	always #5ns clk = ~clk;

	// Rectify one sample into the block sum; close the block every BLOCK_LEN samples
	function automatic bit track_sample(input logic [SAMPLE_W-1:0] s, output reading_t r);
		int unsigned amp;
		int unsigned avg;
		int unsigned blend;
		int unsigned full;
		int unsigned lit;
		amp = (s >= mid_reg) ? int'(s) - int'(mid_reg) : int'(mid_reg) - int'(s);
		run_sum += amp;
		run_count++;
		r = '0;
		if (run_count < BLOCK_LEN)
			return 1'b0;
		avg = run_sum / BLOCK_LEN;
		run_sum = 0;
		run_count = 0;
		blend = int'(held_level) * int'(SMOOTH_OLD_WEIGHT) + avg * int'(SMOOTH_NEW_WEIGHT);
		blend = blend / int'(SMOOTH_DIVISOR);
		held_level = blend[SAMPLE_W-1:0];
		full = (fs_reg == '0) ? 1 : int'(fs_reg);
		lit = int'(held_level) * int'(rows_reg) / full;
		if (lit > rows_reg)
			lit = rows_reg;
		r.level = held_level;
		r.rows = lit[ROWS_W-1:0];
		return 1'b1;
	endfunction

	function automatic int draw_wait(input bit enabled);
		return enabled ? $urandom_range(0, MAX_WAIT) : 0;
	endfunction

	// Build one sample of a block in the given style
	function automatic logic [SAMPLE_W-1:0] shape_sample(input block_style_t sty,
			input logic [SAMPLE_W-1:0] tone, input int unsigned pos);
		int v;
		case (sty)
			STY_FAR: return (mid_reg >= 12'd2048) ? 12'd0 : 12'd4095;
			STY_QUIET: begin
				v = int'(mid_reg) + $urandom_range(0, 16) - 8;
				if (v < 0)
					v = 0;
				if (v > 4095)
					v = 4095;
				return v[SAMPLE_W-1:0];
			end
			STY_SWING: return pos[0] ? 12'd4095 : 12'd0;
			STY_TONE: return tone;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offer one item after a random gap and hold it until taken
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
			input reading_t typed_r);
		int gap;
		reading_t r;
		gap = draw_wait(tx_idle_en);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (track_sample(s, r))
			due_readings.push_back(typed ? typed_r : r);
	endtask

	// Drop valid, wait for every reading, then let the back end go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (due_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic load_settings(input setting_t st, input bit poke_spare);
		logic [SAMPLE_W-1:0] rows_word;
		rows_word = {7'($urandom), st.rows};
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DC_MIDPOINT;
		cfg_data <= st.mid;
		@(posedge clk);
		cfg_index <= REG_FULL_SCALE;
		cfg_data <= st.fs;
		@(posedge clk);
		cfg_index <= REG_BAR_ROWS;
		cfg_data <= rows_word;
		@(posedge clk);
		// the spare index holds no register and must change nothing
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= SAMPLE_W'($urandom);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		mid_reg = st.mid;
		fs_reg = st.fs;
		rows_reg = rows_word[ROWS_W-1:0];
	endtask

	task automatic note_bad(input string what, input reading_t want, input reading_t got);
		bad_count++;
		if (bad_count <= REPORT_MAX)
			$display("%0t %s: expected level %0d rows %0d, got level %0d rows %0d",
				$realtime, what, want.level, want.rows, got.level, got.rows);
	endtask

	// Take results, check them against the oldest expectation, draw the next stall
	always @(posedge clk) begin : take_results
		reading_t got;
		reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.level = smoothed_level;
			got.rows = lit_rows;
			if (due_readings.size() == 0) begin
				note_bad("unexpected reading", '0, got);
			end else begin
				want = due_readings.pop_front();
				if (got.level !== want.level || got.rows !== want.rows)
					note_bad("reading differs", want, got);
			end
			hold_left = draw_wait(rx_idle_en);
		end else if (hold_left != 0) begin
			hold_left--;
		end
		out_stall <= (hold_left != 0);
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("vu_meter_level_tracker: mismatch");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		setting_t     st;
		block_style_t sty;
		logic [SAMPLE_W-1:0] tone;
		int  phase_len;
		bit  fresh;
		run_sum = 0;
		run_count = 0;
		held_level = '0;
		mid_reg = DC_MIDPOINT_RST;
		fs_reg = FULL_SCALE_RST;
		rows_reg = BAR_ROWS_RST;
		sty = STY_NOISE;
		tone = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed probes at reset settings
		foreach (PROBES[i])
			send_sample(PROBES[i].sample, PROBES[i].typed, {PROBES[i].level, PROBES[i].rows});

		// Random phases, each under its own register settings
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle();
			if (p < 5) begin
				st = CORNERS[p];
			end else begin
				st.mid = SAMPLE_W'($urandom);
				st.fs = SAMPLE_W'($urandom);
				st.rows = ROWS_W'($urandom);
			end
			load_settings(st, p == 2 || p == 7);
			tx_idle_en = (p % 3 != 1);
			rx_idle_en = (p % 4 != 2);
			phase_len = $urandom_range(140, 200);
			fresh = 1'b1;
			for (int n = 0; n < phase_len; n++) begin
				// pick a new style at each block boundary; open a phase at the far rail
				if (run_count == 0) begin
					sty = fresh ? STY_FAR : block_style_t'($urandom_range(0, 4));
					tone = SAMPLE_W'($urandom);
					fresh = 1'b0;
				end
				send_sample(shape_sample(sty, tone, run_count), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (due_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (due_readings.size() != 0) begin
			bad_count += due_readings.size();
			$display("%0d readings never arrived", due_readings.size());
		end

		if (bad_count == 0)
			$display("vu_meter_level_tracker: match");
		else
			$display("vu_meter_level_tracker: mismatch");
		$finish;
	end

endmodule

### filelist.f
rtl/vumlt_pkg.sv
rtl/vumlt_front.sv
rtl/vumlt_fifo.sv
rtl/vumlt_div.sv
rtl/vumlt_back.sv
rtl/vu_meter_level_tracker.sv
tb/tb_top.sv
